### hw/rtl/bsb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bsb_pkg;
  localparam int unsigned MaxNodes = 64;
  localparam int unsigned MaxDegree = 7;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] RegNumNodes = 1'd0;
  localparam logic [CfgIdxW-1:0] RegDegree = 1'd1;
  localparam logic [6:0] ResetNodes = 7'd4;
  localparam logic [2:0] ResetDegree = 3'd3;
  localparam int unsigned UW = 17;
  localparam int unsigned IdxW = 6;
  localparam int unsigned WtW = 17;

  typedef struct packed {
    logic [6:0] nodes;
    logic [3:0] degree;
    logic       ok;
  } bsb_cfg_t;
endpackage
`default_nettype wire

### hw/rtl/bsb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bsb_front #(
  parameter int unsigned FRAC_BITS = bsb_pkg::FracBits
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire bsb_pkg::bsb_cfg_t        cfg_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [bsb_pkg::UW-1:0]   u_i,
  output logic                          q_valid_o,
  input  wire logic                     q_ready_i,
  output logic [FRAC_BITS:0]            q_u_o,
  output logic                          q_bad_o
);
  import bsb_pkg::*;
  localparam logic [FRAC_BITS:0] One = {1'b1, {FRAC_BITS{1'b0}}};
  localparam int unsigned Depth = 2;

  logic [FRAC_BITS:0] fifo_u_q [Depth];
  logic               fifo_b_q [Depth];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;
  logic [FRAC_BITS:0] u_sat;
  logic               push, pop;

  always_comb begin
    if (u_i > UW'(One)) begin
      u_sat = One;
    end else begin
      u_sat = u_i[FRAC_BITS:0];
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_u_o = fifo_u_q[rp_q];
  assign q_bad_o = fifo_b_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_u_q[wp_q] <= u_sat;
      fifo_b_q[wp_q] <= !cfg_i.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count mismatch");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_o |-> q_u_o <= One)
    else $error("unsaturated parameter");
endmodule
`default_nettype wire

### hw/rtl/bsb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bsb_back #(
  parameter int unsigned MAX_NODES = bsb_pkg::MaxNodes,
  parameter int unsigned MAX_DEGREE = bsb_pkg::MaxDegree,
  parameter int unsigned FRAC_BITS = bsb_pkg::FracBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bsb_pkg::bsb_cfg_t         cfg_i,
  input  wire logic                      q_valid_i,
  output logic                           q_ready_o,
  input  wire logic [FRAC_BITS:0]        q_u_i,
  input  wire logic                      q_bad_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [bsb_pkg::IdxW-1:0]       node_index_o,
  output logic [bsb_pkg::WtW-1:0]        weight_o,
  output logic                           last_o,
  output logic                           bad_config_o
);
  import bsb_pkg::*;
  localparam int unsigned VW = FRAC_BITS + 1;
  localparam int unsigned KW = $clog2(MAX_NODES + MAX_DEGREE + 2);
  localparam int unsigned AW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned DW = AW + 1;
  localparam int unsigned PW = 2 * VW;
  localparam int unsigned CW = $clog2(VW + 1);
  localparam logic [VW-1:0] One = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_KSET, S_DIV, S_KDONE, S_SRCH, S_ROW, S_DEN, S_MUL, S_OUT
  } state_e;

  typedef enum logic [2:0] {
    P_SRCH_LO, P_SRCH_HI, P_LEFT, P_RIGHT, P_SPLIT
  } purpose_e;

  state_e             state_q;
  purpose_e           purp_q;
  logic [VW-1:0]      u_q;
  logic [KW-1:0]      lo_q, hi_q, mid_q, span_q, kidx_q, nn_q;
  logic [DW-1:0]      j_q, r_q, k_q, p_q;
  logic [VW-1:0]      nb_q [MAX_DEGREE+1];
  logic [VW-1:0]      lf_q [MAX_DEGREE+1];
  logic [VW-1:0]      rt_q [MAX_DEGREE+1];
  logic [VW-1:0]      carry_q, den_q, res_q;
  logic [VW-1:0]      ka_q, kb_q;
  logic [VW-1:0]      rem_q, lob_q, quo_q;
  logic [CW-1:0]      cnt_q;
  logic               out_valid_q;
  logic               ob_q;
  logic [IdxW-1:0]    oidx_q;
  logic [WtW-1:0]     ow_q;
  logic               olast_q;

  logic [KW-1:0]      nspan;
  logic [PW-1:0]      knum, snum;
  logic [VW:0]        rem_sh, rem_diff;
  logic               idle_take, out_load;

  function automatic logic [KW-1:0] mid_of(logic [KW-1:0] a, logic [KW-1:0] b);
    logic [KW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[KW:1];
  endfunction

  // Interior knots are rebuilt on demand as ((i - p) * ONE + L / 2) / L.
  assign nspan = nn_q - KW'(p_q);
  assign knum = (PW'(kidx_q - KW'(p_q)) << FRAC_BITS) + PW'(nspan >> 1);
  assign snum = PW'(nb_q[AW'(r_q)]) * PW'(rt_q[AW'(r_q + DW'(1))]) + PW'(den_q >> 1);
  assign rem_sh = {rem_q, lob_q[VW-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};

  assign q_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign idle_take = q_valid_i && q_ready_o;
  assign out_load = (idle_take && q_bad_i)
                    || ((state_q == S_OUT) && (!out_valid_q || out_ready_i));

  assign out_valid_o = out_valid_q;
  assign node_index_o = oidx_q;
  assign weight_o = ow_q;
  assign last_o = olast_q;
  assign bad_config_o = ob_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      purp_q <= P_SRCH_LO;
      u_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      mid_q <= '0;
      span_q <= '0;
      kidx_q <= '0;
      nn_q <= '0;
      j_q <= '0;
      r_q <= '0;
      k_q <= '0;
      p_q <= '0;
      for (int i = 0; i <= MAX_DEGREE; i++) begin
        nb_q[i] <= '0;
        lf_q[i] <= '0;
        rt_q[i] <= '0;
      end
      carry_q <= '0;
      den_q <= '0;
      res_q <= '0;
      ka_q <= '0;
      kb_q <= '0;
      rem_q <= '0;
      lob_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      ob_q <= 1'b0;
      oidx_q <= '0;
      ow_q <= '0;
      olast_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (idle_take) begin
            u_q <= q_u_i;
            p_q <= DW'(cfg_i.degree);
            nn_q <= KW'(cfg_i.nodes);
            j_q <= DW'(1);
            for (int i = 0; i <= MAX_DEGREE; i++) begin
              nb_q[i] <= (i == 0) ? One : '0;
            end
            if (q_bad_i) begin
              oidx_q <= '0;
              ow_q <= '0;
              olast_q <= 1'b1;
              ob_q <= 1'b1;
            end else if (q_u_i == One) begin
              span_q <= KW'(cfg_i.nodes) - KW'(1);
              state_q <= S_ROW;
            end else begin
              lo_q <= KW'(cfg_i.degree);
              hi_q <= KW'(cfg_i.nodes);
              mid_q <= mid_of(KW'(cfg_i.degree), KW'(cfg_i.nodes));
              kidx_q <= mid_of(KW'(cfg_i.degree), KW'(cfg_i.nodes));
              purp_q <= P_SRCH_LO;
              state_q <= S_KSET;
            end
          end
        end
        S_KSET: begin
          if (kidx_q <= KW'(p_q)) begin
            res_q <= '0;
            state_q <= S_KDONE;
          end else if (kidx_q >= nn_q) begin
            res_q <= One;
            state_q <= S_KDONE;
          end else begin
            den_q <= VW'(nspan);
            rem_q <= knum[PW-1:VW];
            lob_q <= knum[VW-1:0];
            quo_q <= '0;
            cnt_q <= CW'(VW);
            state_q <= S_DIV;
          end
        end
        // The quotient is known to fit in VW bits, so VW steps suffice.
        S_DIV: begin
          if (cnt_q == '0) begin
            res_q <= quo_q;
            state_q <= S_KDONE;
          end else begin
            if (rem_sh >= {1'b0, den_q}) begin
              rem_q <= rem_diff[VW-1:0];
              quo_q <= {quo_q[VW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh[VW-1:0];
              quo_q <= {quo_q[VW-2:0], 1'b0};
            end
            lob_q <= {lob_q[VW-2:0], 1'b0};
            cnt_q <= cnt_q - CW'(1);
          end
        end
        S_KDONE: begin
          case (purp_q)
            P_SRCH_LO: begin
              ka_q <= res_q;
              kidx_q <= mid_q + KW'(1);
              purp_q <= P_SRCH_HI;
              state_q <= S_KSET;
            end
            P_SRCH_HI: begin
              kb_q <= res_q;
              state_q <= S_SRCH;
            end
            P_LEFT: begin
              lf_q[AW'(j_q)] <= u_q - res_q;
              kidx_q <= span_q + KW'(j_q);
              purp_q <= P_RIGHT;
              state_q <= S_KSET;
            end
            P_RIGHT: begin
              rt_q[AW'(j_q)] <= res_q - u_q;
              r_q <= '0;
              carry_q <= '0;
              state_q <= S_DEN;
            end
            P_SPLIT: begin
              nb_q[AW'(r_q)] <= carry_q + res_q;
              carry_q <= nb_q[AW'(r_q)] - res_q;
              r_q <= r_q + DW'(1);
              state_q <= S_DEN;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_SRCH: begin
          if (u_q >= ka_q && u_q < kb_q) begin
            span_q <= mid_q;
            state_q <= S_ROW;
          end else begin
            if (u_q < ka_q) begin
              hi_q <= mid_q;
              mid_q <= mid_of(lo_q, mid_q);
              kidx_q <= mid_of(lo_q, mid_q);
            end else begin
              lo_q <= mid_q;
              mid_q <= mid_of(mid_q, hi_q);
              kidx_q <= mid_of(mid_q, hi_q);
            end
            purp_q <= P_SRCH_LO;
            state_q <= S_KSET;
          end
        end
        S_ROW: begin
          if (j_q > p_q) begin
            k_q <= '0;
            state_q <= S_OUT;
          end else begin
            kidx_q <= span_q + KW'(1) - KW'(j_q);
            purp_q <= P_LEFT;
            state_q <= S_KSET;
          end
        end
        S_DEN: begin
          if (r_q == j_q) begin
            nb_q[AW'(j_q)] <= carry_q;
            j_q <= j_q + DW'(1);
            state_q <= S_ROW;
          end else begin
            den_q <= rt_q[AW'(r_q + DW'(1))] + lf_q[AW'(j_q - r_q)];
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (den_q == '0) begin
            nb_q[AW'(r_q)] <= carry_q;
            carry_q <= '0;
            r_q <= r_q + DW'(1);
            state_q <= S_DEN;
          end else begin
            rem_q <= snum[PW-1:VW];
            lob_q <= snum[VW-1:0];
            quo_q <= '0;
            cnt_q <= CW'(VW);
            purp_q <= P_SPLIT;
            state_q <= S_DIV;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            oidx_q <= IdxW'(span_q - KW'(p_q) + KW'(k_q));
            ow_q <= WtW'(nb_q[AW'(k_q)]);
            olast_q <= (k_q == p_q);
            ob_q <= 1'b0;
            k_q <= k_q + DW'(1);
            if (k_q == p_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(weight_o) && $stable(node_index_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_config_o) |-> last_o)
    else $error("bad config not last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> state_q == S_IDLE)
    else $error("accept while busy");
endmodule
`default_nettype wire

### hw/rtl/bspline_basis_evaluator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// One transfer is processed at a time; a search step evaluates two knots, each
// Cox-de Boor split takes one division, and each interior knot is rebuilt by one division.
// The shared divider produces one quotient bit per cycle and sets the rate.
// Reset is asynchronous and active low and loads four nodes and degree three.
module bspline_basis_evaluator_top #(
  parameter int unsigned MAX_NODES = bsb_pkg::MaxNodes,
  parameter int unsigned MAX_DEGREE = bsb_pkg::MaxDegree,
  parameter int unsigned FRAC_BITS = bsb_pkg::FracBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bsb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bsb_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [bsb_pkg::UW-1:0]       u_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [bsb_pkg::IdxW-1:0]          node_index_o,
  output logic [bsb_pkg::WtW-1:0]           weight_o,
  output logic                              last_o,
  output logic                              bad_config_o
);
  import bsb_pkg::*;
  logic [6:0]         nodes_q;
  logic [2:0]         deg_q;
  bsb_cfg_t           cfg;
  logic               qv, qr, qb;
  logic [FRAC_BITS:0] qu;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q <= ResetNodes;
      deg_q <= ResetDegree;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegNumNodes: nodes_q <= cfg_data_i;
        RegDegree:   deg_q <= cfg_data_i[2:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    cfg.nodes = (32'(nodes_q) > MAX_NODES) ? 7'(MAX_NODES) : nodes_q;
    cfg.degree = {1'b0, deg_q};
    cfg.ok = (32'(deg_q) <= MAX_DEGREE) && ({4'd0, deg_q} < cfg.nodes);
  end

  bsb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_valid_i, .in_ready_o, .u_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_u_o(qu), .q_bad_o(qb)
  );

  bsb_back #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .q_valid_i(qv), .q_ready_o(qr), .q_u_i(qu),
    .q_bad_i(qb), .out_valid_o, .out_ready_i, .node_index_o, .weight_o, .last_o,
    .bad_config_o
  );
endmodule
`default_nettype wire
